>>> rtl/core/mavg_pkg.sv
// shared types, constants and field layout for the moving-average level alarm
// no dependencies; imported by every module of the block except mavg_ram
package mavg_pkg;

	localparam int unsigned SAMPLE_W   = 17;
	localparam int unsigned RATE_W     = 18;
	localparam int unsigned LEVEL_W    = 2;
	localparam int unsigned WINDOW_DEF = 512;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 17'd99999;

	// alarm levels
	localparam logic [LEVEL_W-1:0] LVL_GREEN  = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_YELLOW = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_RED    = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_EXCESS_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXCESS_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_CAUTION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DANGER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_CAUTION   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_DANGER    = 3'd5;

	// configuration reset values
	localparam logic [SAMPLE_W-1:0] RST_EXCESS_LOW     = 17'd1000;
	localparam logic [SAMPLE_W-1:0] RST_EXCESS_HIGH    = 17'd5000;
	localparam logic [SAMPLE_W-1:0] RST_SAMPLE_CAUTION = 17'd5000;
	localparam logic [SAMPLE_W-1:0] RST_SAMPLE_DANGER  = 17'd10000;
	localparam logic [SAMPLE_W-1:0] RST_RATE_CAUTION   = 17'd1000;
	localparam logic [SAMPLE_W-1:0] RST_RATE_DANGER    = 17'd2000;

	// stream word layout
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 40;
	localparam int unsigned AVG_LSB     = 0;
	localparam int unsigned RATE_LSB    = AVG_LSB + SAMPLE_W;
	localparam int unsigned LEVEL_LSB   = RATE_LSB + RATE_W;
	localparam int unsigned FULL_BIT    = LEVEL_LSB + LEVEL_W;

	typedef struct packed {
		logic [SAMPLE_W-1:0] excess_low;
		logic [SAMPLE_W-1:0] excess_high;
		logic [SAMPLE_W-1:0] sample_caution;
		logic [SAMPLE_W-1:0] sample_danger;
		logic [SAMPLE_W-1:0] rate_caution;
		logic [SAMPLE_W-1:0] rate_danger;
	} cfg_t;

	// per-word payload carried down the pipeline
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [RATE_W-1:0]   rate;   // two's complement
		logic                full;
	} item_t;

endpackage

>>> rtl/core/moving_average_level_alarm_top.sv
// top level of the moving-average gas level alarm
// depends on mavg_pkg, mavg_window, mavg_div and mavg_level
//
// usage:
//  - s_axis carries one concentration sample per word (hundredths of ppm);
//    values above 99999 are clamped before use
//  - m_axis returns one result word per sample: window average, rate of
//    change, alarm level and the window-full flag
//  - cfg_* writes one of six threshold registers per handshake; cfg_ready
//    is always high; indexes above five are dropped; write only when idle
//  - throughput: one sample per cycle while m_axis takes results; the
//    ring is read and written at the same address in the accept cycle,
//    and the running-sum update sits one stage later, so back-to-back
//    words never collide
//  - average and rate read zero until WINDOW samples have been taken
//  - reset clears the pointer, sum, flags and pipeline, loads the default
//    thresholds and sets the level to green; ring contents are not cleared,
//    only entries already written are ever read
//  - when m_axis stalls, results queue in the six pipeline stages and
//    s_axis_tready drops only once every stage holds a word
module moving_average_level_alarm_top
	import mavg_pkg::*;
#(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// sample word in
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [16:0] sample, rest zero
	// result word out
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [16:0] window_average,
	                                              // [34:17] rate_of_change,
	                                              // [36:35] alarm_level,
	                                              // [37] window_full, rest zero
	// threshold register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SAMPLE_W-1:0]    cfg_data
);

	localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);

	cfg_t cfg_q;

	// window -> divider
	logic                v_win, r_win;
	item_t               item_win;
	logic [SUM_W-1:0]    sum_win;
	// divider -> classifier
	logic                v_div, r_div;
	item_t               item_div;
	logic [SAMPLE_W-1:0] avg_div;
	// classifier -> port
	item_t               item_out;
	logic [SAMPLE_W-1:0] avg_out;
	logic [LEVEL_W-1:0]  level_out;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.excess_low     <= RST_EXCESS_LOW;
			cfg_q.excess_high    <= RST_EXCESS_HIGH;
			cfg_q.sample_caution <= RST_SAMPLE_CAUTION;
			cfg_q.sample_danger  <= RST_SAMPLE_DANGER;
			cfg_q.rate_caution   <= RST_RATE_CAUTION;
			cfg_q.rate_danger    <= RST_RATE_DANGER;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXCESS_LOW:     cfg_q.excess_low     <= cfg_data;
				REG_EXCESS_HIGH:    cfg_q.excess_high    <= cfg_data;
				REG_SAMPLE_CAUTION: cfg_q.sample_caution <= cfg_data;
				REG_SAMPLE_DANGER:  cfg_q.sample_danger  <= cfg_data;
				REG_RATE_CAUTION:   cfg_q.rate_caution   <= cfg_data;
				REG_RATE_DANGER:    cfg_q.rate_danger    <= cfg_data;
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// ring, pointer and running sum
	mavg_window #(
		.WINDOW(WINDOW)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_sample(s_axis_tdata[SAMPLE_W-1:0]),
		.out_valid(v_win),
		.out_ready(r_win),
		.out_item (item_win),
		.out_sum  (sum_win)
	);

	// sum / WINDOW
	mavg_div #(
		.WINDOW(WINDOW)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_win),
		.in_ready   (r_win),
		.in_item    (item_win),
		.in_sum     (sum_win),
		.out_valid  (v_div),
		.out_ready  (r_div),
		.out_item   (item_div),
		.out_average(avg_div)
	);

	// level decision and result register
	mavg_level u_level (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (v_div),
		.in_ready   (r_div),
		.in_item    (item_div),
		.in_average (avg_div),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_item   (item_out),
		.out_average(avg_out),
		.out_level  (level_out)
	);

	// pack the result word, highest field first
	assign m_axis_tdata = {
		(OUT_TDATA_W - FULL_BIT - 1)'(0),
		item_out.full,
		level_out,
		item_out.rate,
		avg_out
	};

endmodule

>>> rtl/core/mavg_ram.sv
// generic single-write, single-read ram with registered read data
// read-first on a same-address write; no dependencies
module mavg_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

>>> rtl/core/mavg_window.sv
// sample ring, write pointer, fill tracking and running sum (stages 1 and 2)
// depends on mavg_pkg and mavg_ram
module mavg_window
	import mavg_pkg::*;
#(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [SAMPLE_W-1:0]                   in_sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output item_t                                 out_item,
	output logic [SAMPLE_W+$clog2(WINDOW)-1:0]    out_sum
);

	localparam int unsigned POS_W = $clog2(WINDOW);
	localparam int unsigned SUM_W = SAMPLE_W + POS_W;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);

	logic [POS_W-1:0]    pos_q;
	logic                filled_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic [SUM_W-1:0]    sum_q;

	logic                v_s1, v_s2;
	item_t               item_s1, item_s2;
	logic                sub_s1;
	logic [SUM_W-1:0]    sum_s2;
	logic [SAMPLE_W-1:0] old_s1;

	logic                rdy_s1, rdy_s2, acc, move_s2;
	logic [SAMPLE_W-1:0] sat;
	logic                last_slot, full_next;
	logic [RATE_W-1:0]   diff, rate;
	logic [SUM_W-1:0]    sum_next;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign acc      = in_valid && rdy_s1;
	assign move_s2  = v_s1 && rdy_s2;

	assign sat       = (in_sample > SAMPLE_MAX) ? SAMPLE_MAX : in_sample;
	assign last_slot = (pos_q == LAST_POS);
	assign full_next = filled_q || last_slot;
	assign diff      = {1'b0, sat} - {1'b0, prev_q};
	assign rate      = full_next ? diff : '0;

	// old entry is read in the same cycle it is overwritten
	mavg_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (acc),
		.waddr(pos_q),
		.wdata(sat),
		.re   (acc && filled_q),
		.raddr(pos_q),
		.rdata(old_s1)
	);

	assign sum_next = sum_q + SUM_W'(item_s1.sample) - (sub_s1 ? SUM_W'(old_s1) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= 1'b0;
			prev_q   <= '0;
			sum_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (acc) begin
				pos_q    <= last_slot ? '0 : pos_q + 1'b1;
				filled_q <= full_next;
				prev_q   <= sat;
			end
			if (move_s2) begin
				sum_q <= sum_next;
			end
			if (rdy_s1) begin
				v_s1 <= acc;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= '{sample: sat, rate: rate, full: full_next};
			sub_s1  <= filled_q;
		end
		if (move_s2) begin
			item_s2 <= item_s1;
			sum_s2  <= sum_next;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;
	assign out_sum   = sum_s2;

endmodule

>>> rtl/core/mavg_div.sv
// divides the running sum by the window length: reciprocal multiply,
// back-multiply and one correction step (stages 3 to 5); depends on mavg_pkg
module mavg_div
	import mavg_pkg::*;
#(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  item_t                              in_item,
	input  logic [SAMPLE_W+$clog2(WINDOW)-1:0] in_sum,
	output logic                               out_valid,
	input  logic                               out_ready,
	output item_t                              out_item,
	output logic [SAMPLE_W-1:0]                out_average
);

	localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);
	// floor(2^SUM_W / WINDOW); estimate is exact or one low
	localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW);
	localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW);

	logic                 v_s3, v_s4, v_s5;
	logic                 rdy_s3, rdy_s4, rdy_s5;
	item_t                item_s3, item_s4, item_s5;
	logic [SUM_W-1:0]     sum_s3, sum_s4;
	logic [2*SUM_W-1:0]   prod_s3;
	logic [SAMPLE_W-1:0]  qe_s4, avg_s5;
	logic [SUM_W-1:0]     qw_s4;

	logic [SAMPLE_W-1:0]  qe;
	logic [SUM_W-1:0]     rem;
	logic [SAMPLE_W-1:0]  quot;

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	assign qe   = prod_s3[SUM_W+SAMPLE_W-1:SUM_W];
	assign rem  = sum_s4 - qw_s4;
	assign quot = (rem >= WIN_C) ? qe_s4 + 1'b1 : qe_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= in_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			item_s3 <= in_item;
			sum_s3  <= in_sum;
			prod_s3 <= in_sum * RECIP;
		end
		if (rdy_s4 && v_s3) begin
			item_s4 <= item_s3;
			sum_s4  <= sum_s3;
			qe_s4   <= qe;
			qw_s4   <= SUM_W'(qe) * WIN_C;
		end
		if (rdy_s5 && v_s4) begin
			item_s5 <= item_s4;
			// average stays zero until the ring has been filled once
			avg_s5  <= item_s4.full ? quot : '0;
		end
	end

	assign out_valid   = v_s5;
	assign out_item    = item_s5;
	assign out_average = avg_s5;

endmodule

>>> rtl/core/mavg_level.sv
// alarm classification with level hold, and the result register
// depends on mavg_pkg
module mavg_level
	import mavg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  item_t               in_item,
	input  logic [SAMPLE_W-1:0] in_average,
	output logic                out_valid,
	input  logic                out_ready,
	output item_t               out_item,
	output logic [SAMPLE_W-1:0] out_average,
	output logic [LEVEL_W-1:0]  out_level
);

	logic                v_q;
	logic [LEVEL_W-1:0]  level_q;
	item_t               item_q;
	logic [SAMPLE_W-1:0] avg_q;

	logic                load;
	logic signed [SAMPLE_W+1:0] ex, rt, exl, exh, rc, rd;
	logic                green, yellow, red;
	logic [LEVEL_W-1:0]  level_next;

	assign in_ready = !v_q || out_ready;
	assign load     = in_valid && in_ready;

	// signed compares on 19 bits: excess and rate can go negative
	assign ex  = $signed({2'b00, in_item.sample}) - $signed({2'b00, in_average});
	assign rt  = $signed({in_item.rate[RATE_W-1], in_item.rate});
	assign exl = $signed({2'b00, cfg.excess_low});
	assign exh = $signed({2'b00, cfg.excess_high});
	assign rc  = $signed({2'b00, cfg.rate_caution});
	assign rd  = $signed({2'b00, cfg.rate_danger});

	assign green  = (ex <= exl) && (in_item.sample < cfg.sample_caution) && (rt < rc);
	assign yellow = ((ex > exl) && (ex < exh) && (in_item.sample < cfg.sample_danger))
		|| ((rt >= rc) && (rt < rd));
	assign red    = (ex >= exh) || (in_item.sample >= cfg.sample_danger)
		|| (in_average >= cfg.sample_danger) || (rt >= rd);

	always_comb begin
		level_next = level_q;
		if (green) begin
			level_next = LVL_GREEN;
		end else if (yellow) begin
			level_next = LVL_YELLOW;
		end else if (red) begin
			level_next = LVL_RED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= 1'b0;
			level_q <= LVL_GREEN;
		end else begin
			if (in_ready) begin
				v_q <= in_valid;
			end
			if (load) begin
				level_q <= level_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= in_item;
			avg_q  <= in_average;
		end
	end

	assign out_valid   = v_q;
	assign out_item    = item_q;
	assign out_average = avg_q;
	assign out_level   = level_q;

endmodule

>>> rtl/core/mavg_checker.sv
// port-level checks for moving_average_level_alarm_top, attached by bind
// depends on mavg_pkg
module mavg_checker
	import mavg_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// before the first fill, average and rate read zero
	a_zero_until_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[FULL_BIT]
		|-> m_axis_tdata[LEVEL_LSB-1:AVG_LSB] == '0)
		else $error("nonzero average or rate before window full");

	// mean of clamped samples cannot exceed the clamp
	a_avg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[RATE_LSB-1:AVG_LSB] <= SAMPLE_MAX)
		else $error("window average above sample range");

	// level never takes the unused code
	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[FULL_BIT-1:LEVEL_LSB] != 2'd3)
		else $error("alarm level out of range");

endmodule

bind moving_average_level_alarm_top mavg_checker u_mavg_checker (.*);
